/* rtl/mme_pkg.sv */
package mme_pkg;

   localparam int DIM_WIDTH = 4;

   typedef enum logic [1:0] {
      FUNC_LOAD_A = 2'd0,
      FUNC_LOAD_B = 2'd1,
      FUNC_START  = 2'd2,
      FUNC_NONE   = 2'd3
   } func_type;

   localparam logic [1:0] CSR_ROWS_A = 2'd0;
   localparam logic [1:0] CSR_COLS_A = 2'd1;
   localparam logic [1:0] CSR_ROWS_B = 2'd2;
   localparam logic [1:0] CSR_COLS_B = 2'd3;

   typedef struct packed {
      logic clear;
      logic shift;
   } cell_ctl_type;

endpackage

/* rtl/mme_mac_cell.sv */
module mme_mac_cell (
   input  logic                clock,
   input  mme_pkg::cell_ctl_type ctl,
   input  logic                take,
   input  logic [31:0]         a_value,
   input  logic [31:0]         b_value,
   input  logic [31:0]         prev_sum,
   output logic [31:0]         b_pass,
   output logic [31:0]         sum
);
   import mme_pkg::*;

   logic [31:0] prod_ff;
   logic [31:0] prod_in;
   logic [31:0] acc_ff;
   logic [31:0] acc_in;
   logic        take_ff;
   logic [31:0] b_ff;

   assign prod_in = a_value * b_value;

   always_comb begin
      acc_in = acc_ff;
      if (ctl.clear) begin
         acc_in = '0;
      end else if (ctl.shift) begin
         acc_in = prev_sum;
      end else if (take_ff) begin
         acc_in = acc_ff + prod_ff;
      end
   end

   always_ff @(posedge clock) begin
      prod_ff <= prod_in;
      take_ff <= take & ~ctl.clear & ~ctl.shift;
      acc_ff  <= acc_in;
      b_ff    <= b_value;
   end

   assign b_pass = b_ff;
   assign sum    = acc_ff;
endmodule

/* rtl/matrix_multiply_engine.sv */
// Matrix multiply engine. Load items (func 0 for A, 1 for B) are taken one per cycle while
// the engine is idle and written row-major into two element memories; each store holds
// MAX_DIM*MAX_DIM elements and further loads are dropped. A start item (func 2) compares
// cols_a with rows_b: on a mismatch one item with dim_error set is returned in the next
// cycle. Otherwise one row of C is computed at a time by a chain of MAX_DIM multiply-
// accumulate cells, one cell per output column. For each k the row of B is read one element
// per cycle, last column first, and shifted along the chain; when it is in place every cell
// multiplies it by A[i][k]. After the walk over k the pipeline drains, and the row sums then
// shift out of the chain one per cycle while the receiver does not stall, cols_b items per
// row. The input is stalled after a start until the last result or error item is taken.
module matrix_multiply_engine #(
   parameter int MAX_DIM    = 8,
   parameter int DATA_WIDTH = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_valid,
   output logic                           req_stall,
   input  logic [1:0]                     req_func,
   input  logic signed [31:0]             req_value,
   output logic                           rsp_valid,
   input  logic                           rsp_stall,
   output logic signed [31:0]             rsp_product,
   output logic [2:0]                     rsp_out_row,
   output logic [2:0]                     rsp_out_col,
   output logic                           rsp_last,
   output logic                           rsp_dim_error,
   input  logic                           csr_write,
   input  logic [1:0]                     csr_index,
   input  logic [mme_pkg::DIM_WIDTH-1:0]  csr_data
);
   import mme_pkg::*;

   localparam int DEPTH = MAX_DIM * MAX_DIM;
   localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int FW    = $clog2(DEPTH + 1);
   localparam int KW    = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
   localparam int CW    = $clog2(MAX_DIM + 1);

   typedef enum logic [2:0] {
      ST_IDLE, ST_MAC, ST_DRAIN, ST_OUT, ST_ERR
   } state_type;

   logic [31:0] a_mem [DEPTH];
   logic [31:0] b_mem [DEPTH];
   logic [FW-1:0] a_fill_ff, b_fill_ff;
   logic [DIM_WIDTH-1:0] rows_a_ff, cols_a_ff, rows_b_ff, cols_b_ff;
   state_type state_ff;
   logic [KW-1:0] row_ff, k_ff, col_ff, bj_ff;
   logic [1:0] drain_ff;
   logic [CW-1:0] ra, ca, rb, cb;
   logic [31:0] elem;
   logic accept, out_ok;
   logic [31:0] a_rd_ff;
   logic [31:0] b_rd_ff;
   logic rd_valid_ff;
   cell_ctl_type ctl;
   logic [31:0] sums [MAX_DIM];
   logic [31:0] chain [MAX_DIM+1];
   logic [31:0] b_link [MAX_DIM+1];

   function automatic logic [CW-1:0] eff(input logic [DIM_WIDTH-1:0] d);
      if (d == '0) begin
         return CW'(1);
      end else if (32'(d) > MAX_DIM) begin
         return CW'(MAX_DIM);
      end
      return CW'(d);
   endfunction

   assign ra = eff(rows_a_ff);
   assign ca = eff(cols_a_ff);
   assign rb = eff(rows_b_ff);
   assign cb = eff(cols_b_ff);
   assign elem = 32'(signed'(req_value[DATA_WIDTH-1:0]));
   assign req_stall = (state_ff != ST_IDLE);
   assign accept = req_valid & ~req_stall;
   assign out_ok = rsp_valid & ~rsp_stall;

   always_ff @(posedge clock) begin
      if (accept && req_func == FUNC_LOAD_A && a_fill_ff < FW'(DEPTH)) begin
         a_mem[a_fill_ff[AW-1:0]] <= elem;
      end
      if (accept && req_func == FUNC_LOAD_B && b_fill_ff < FW'(DEPTH)) begin
         b_mem[b_fill_ff[AW-1:0]] <= elem;
      end
   end

   // row i of A at k, row k of B one column per cycle from the last
   always_ff @(posedge clock) begin
      a_rd_ff <= a_mem[AW'(32'(row_ff) * 32'(ca) + 32'(k_ff))];
      b_rd_ff <= b_mem[AW'(32'(k_ff) * 32'(cb) + 32'(bj_ff))];
   end

   always_comb begin
      ctl.clear = (state_ff == ST_IDLE) || (state_ff == ST_OUT && out_ok &&
                  32'(col_ff) + 1 == 32'(cb));
      ctl.shift = (state_ff == ST_OUT) && out_ok && !ctl.clear;
   end

   assign chain[MAX_DIM] = '0;
   assign b_link[0] = b_rd_ff;
   for (genvar j = 0; j < MAX_DIM; j++) begin : g_cell
      mme_mac_cell u_cell (
         .clock   (clock),
         .ctl     (ctl),
         .take    (rd_valid_ff),
         .a_value (a_rd_ff),
         .b_value (b_link[j]),
         .prev_sum(chain[j+1]),
         .b_pass  (b_link[j+1]),
         .sum     (sums[j])
      );
      assign chain[j] = sums[j];
   end

   assign rsp_product   = (state_ff == ST_ERR) ? '0 : sums[0];
   assign rsp_out_row   = (state_ff == ST_ERR) ? '0 : 3'(row_ff);
   assign rsp_out_col   = (state_ff == ST_ERR) ? '0 : 3'(col_ff);
   assign rsp_dim_error = (state_ff == ST_ERR);
   assign rsp_last      = (state_ff == ST_ERR) ||
                          (32'(row_ff) + 1 == 32'(ra) && 32'(col_ff) + 1 == 32'(cb));
   assign rsp_valid     = (state_ff == ST_OUT) || (state_ff == ST_ERR);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         a_fill_ff   <= '0;
         b_fill_ff   <= '0;
         rows_a_ff   <= DIM_WIDTH'(1);
         cols_a_ff   <= DIM_WIDTH'(1);
         rows_b_ff   <= DIM_WIDTH'(1);
         cols_b_ff   <= DIM_WIDTH'(1);
         row_ff      <= '0;
         k_ff        <= '0;
         col_ff      <= '0;
         bj_ff       <= '0;
         drain_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         rd_valid_ff <= (state_ff == ST_MAC) && (bj_ff == '0);
         if (csr_write) begin
            case (csr_index)
               CSR_ROWS_A: rows_a_ff <= csr_data;
               CSR_COLS_A: cols_a_ff <= csr_data;
               CSR_ROWS_B: rows_b_ff <= csr_data;
               CSR_COLS_B: cols_b_ff <= csr_data;
               default: ;
            endcase
         end
         case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  case (func_type'(req_func))
                     FUNC_LOAD_A: if (a_fill_ff < FW'(DEPTH)) a_fill_ff <= a_fill_ff + 1'b1;
                     FUNC_LOAD_B: if (b_fill_ff < FW'(DEPTH)) b_fill_ff <= b_fill_ff + 1'b1;
                     FUNC_START: begin
                        a_fill_ff <= '0;
                        b_fill_ff <= '0;
                        row_ff    <= '0;
                        k_ff      <= '0;
                        col_ff    <= '0;
                        bj_ff     <= KW'(cb - 1'b1);
                        state_ff  <= (ca != rb) ? ST_ERR : ST_MAC;
                     end
                     default: ;
                  endcase
               end
            end
            ST_MAC: begin
               if (bj_ff == '0) begin
                  bj_ff <= KW'(cb - 1'b1);
                  if (32'(k_ff) + 1 == 32'(ca)) begin
                     k_ff     <= '0;
                     drain_ff <= '0;
                     state_ff <= ST_DRAIN;
                  end else begin
                     k_ff <= k_ff + 1'b1;
                  end
               end else begin
                  bj_ff <= bj_ff - 1'b1;
               end
            end
            ST_DRAIN: begin
               drain_ff <= drain_ff + 1'b1;
               if (drain_ff == 2'd2) begin
                  col_ff   <= '0;
                  state_ff <= ST_OUT;
               end
            end
            ST_OUT: begin
               if (out_ok) begin
                  if (32'(col_ff) + 1 == 32'(cb)) begin
                     col_ff <= '0;
                     if (32'(row_ff) + 1 == 32'(ra)) begin
                        state_ff <= ST_IDLE;
                     end else begin
                        row_ff   <= row_ff + 1'b1;
                        bj_ff    <= KW'(cb - 1'b1);
                        state_ff <= ST_MAC;
                     end
                  end else begin
                     col_ff <= col_ff + 1'b1;
                  end
               end
            end
            ST_ERR: if (out_ok) state_ff <= ST_IDLE;
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_product))
      else $error("result changed under stall");
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("item accepted while results pending");
   a_err_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_dim_error |-> rsp_last && rsp_product == '0)
      else $error("error result malformed");
endmodule

/* tb/sv/matrix_multiply_engine_tb.sv */
module matrix_multiply_engine_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import mme_pkg::*;

   localparam int IDLE_LIMIT = 5000;
   localparam int SETTLE_CYCLES = 40;
   localparam int HOLD_CYCLES = 300;

   typedef struct {
      logic signed [31:0] product;
      logic [2:0]         row;
      logic [2:0]         col;
      logic               last;
      logic               dim_error;
   } c_elem_type;

   class product_scoreboard;
      logic [31:0] a_mem[64];
      logic [31:0] b_mem[64];
      bit          a_seen[64];
      bit          b_seen[64];
      int          a_fill;
      int          b_fill;
      logic [3:0]  dims[4];
      c_elem_type  product_q[$];
      int          errors;
      int          n_checked;
      int          n_dim_errors;

      function new();
         for (int i = 0; i < 64; i++) begin
            a_seen[i] = 0;
            b_seen[i] = 0;
         end
         for (int i = 0; i < 4; i++) dims[i] = 4'd1;
         a_fill = 0;
         b_fill = 0;
         errors = 0;
         n_checked = 0;
         n_dim_errors = 0;
      endfunction

      function int eff_dim(logic [1:0] idx);
         if (dims[idx] == 0) return 1;
         if (dims[idx] > 8) return 8;
         return dims[idx];
      endfunction

      function bit covered(bit b_side, int from, int upto);
         for (int i = from; i < upto; i++) begin
            if (b_side ? !b_seen[i] : !a_seen[i]) return 0;
         end
         return 1;
      endfunction

      function void note_item(logic [1:0] func, logic [31:0] value);
         int         ra, ca, rb, cb;
         logic [31:0] acc;
         c_elem_type e;
         case (func)
            FUNC_LOAD_A: begin
               if (a_fill < 64) begin
                  a_mem[a_fill] = value;
                  a_seen[a_fill] = 1;
                  a_fill++;
               end
            end
            FUNC_LOAD_B: begin
               if (b_fill < 64) begin
                  b_mem[b_fill] = value;
                  b_seen[b_fill] = 1;
                  b_fill++;
               end
            end
            FUNC_START: begin
               a_fill = 0;
               b_fill = 0;
               ra = eff_dim(CSR_ROWS_A);
               ca = eff_dim(CSR_COLS_A);
               rb = eff_dim(CSR_ROWS_B);
               cb = eff_dim(CSR_COLS_B);
               if (ca != rb) begin
                  e.product = 0;
                  e.row = 0;
                  e.col = 0;
                  e.last = 1;
                  e.dim_error = 1;
                  product_q.push_back(e);
               end else begin
                  for (int i = 0; i < ra; i++) begin
                     for (int j = 0; j < cb; j++) begin
                        acc = 0;
                        for (int k = 0; k < ca; k++)
                           acc = acc + a_mem[i * ca + k] * b_mem[k * cb + j];
                        e.product = acc;
                        e.row = i[2:0];
                        e.col = j[2:0];
                        e.last = (i == ra - 1) && (j == cb - 1);
                        e.dim_error = 0;
                        product_q.push_back(e);
                     end
                  end
               end
            end
            default: ;
         endcase
      endfunction

      task report(string msg);
         errors++;
         $display("mismatch: %s", msg);
      endtask

      task check_product(logic signed [31:0] product, logic [2:0] row, logic [2:0] col,
                         logic last, logic dim_error);
         c_elem_type e;
         if (product_q.size() == 0) begin
            report($sformatf("unexpected result product=%0d row=%0d col=%0d",
                             product, row, col));
         end else begin
            e = product_q.pop_front();
            n_checked++;
            if (e.dim_error) n_dim_errors++;
            if (product !== e.product)
               report($sformatf("product %0d, expected %0d at (%0d,%0d)",
                                product, e.product, e.row, e.col));
            if (row !== e.row) report($sformatf("out_row %0d, expected %0d", row, e.row));
            if (col !== e.col) report($sformatf("out_col %0d, expected %0d", col, e.col));
            if (last !== e.last) report($sformatf("last %0b, expected %0b", last, e.last));
            if (dim_error !== e.dim_error)
               report($sformatf("dim_error %0b, expected %0b", dim_error, e.dim_error));
         end
      endtask
   endclass

   logic               clock = 0;
   logic               reset = 1;
   logic               req_valid = 0;
   logic               req_stall;
   logic [1:0]         req_func = FUNC_LOAD_A;
   logic signed [31:0] req_value = 0;
   logic               rsp_valid;
   logic               rsp_stall = 0;
   logic signed [31:0] rsp_product;
   logic [2:0]         rsp_out_row;
   logic [2:0]         rsp_out_col;
   logic               rsp_last;
   logic               rsp_dim_error;
   logic               csr_write = 0;
   logic [1:0]         csr_index = CSR_ROWS_A;
   logic [DIM_WIDTH-1:0] csr_data = 0;

   product_scoreboard sb = new();
   int  n_items = 0;
   int  n_groups = 0;
   bit  req_calm = 0;
   bit  rsp_calm = 0;
   bit  hold_req = 0;
   int  stall_left = 0;
   int  idle_cycles = 0;
   int  rsp_cycle = 0;

   matrix_multiply_engine u_dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_func(req_func),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_product(rsp_product),
      .rsp_out_row(rsp_out_row),
      .rsp_out_col(rsp_out_col),
      .rsp_last(rsp_last),
      .rsp_dim_error(rsp_dim_error),
      .csr_write(csr_write),
      .csr_index(csr_index),
      .csr_data(csr_data)
   );

   always begin
      #2 clock = 1;
      #2 clock = 0;
   end

   function int pick_gap();
      int r;
      r = $urandom % 10;
      if (r < 6) return 0;
      if (r < 9) return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   function logic [31:0] pick_value();
      case ($urandom % 8)
         0: return 32'h8000_0000;
         1: return 32'h7fff_ffff;
         2: return 32'hffff_ffff;
         3: return 32'h0;
         4: return 32'($urandom_range(0, 15)) - 32'd8;
         default: return $urandom;
      endcase
   endfunction

   function logic [3:0] pick_dim();
      case ($urandom % 10)
         0: return 4'd0;
         1: return 4'($urandom_range(9, 15));
         2: return 4'd8;
         default: return 4'($urandom_range(1, 4));
      endcase
   endfunction

   // receiver side stalls
   always @(posedge clock) begin
      rsp_cycle++;
      if (rsp_cycle % 128 == 0) rsp_calm = ($urandom % 4 == 0);
      if (reset) begin
         rsp_stall <= 0;
      end else begin
         if (hold_req) begin
            stall_left = HOLD_CYCLES;
            hold_req = 0;
         end
         if (stall_left > 0) begin
            rsp_stall <= 1;
            stall_left--;
         end else begin
            rsp_stall <= 0;
            if (!rsp_calm && $urandom % 4 == 0) stall_left = pick_gap();
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         sb.check_product(rsp_product, rsp_out_row, rsp_out_col, rsp_last, rsp_dim_error);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) || csr_write) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("timeout after %0d cycles without progress", idle_cycles);
            $display("[FAIL] regression broken");
            $finish;
         end
      end
   end

   task send(logic [1:0] func, logic [31:0] value);
      int gap;
      req_valid <= 1;
      req_func <= func;
      req_value <= value;
      do @(posedge clock); while (req_stall);
      sb.note_item(func, value);
      if (func != FUNC_NONE) n_items++;
      gap = req_calm ? 0 : pick_gap();
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task settle();
      req_valid <= 0;
      while (sb.product_q.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task set_dims(logic [3:0] ra, logic [3:0] ca, logic [3:0] rb, logic [3:0] cb);
      req_valid <= 0;
      @(posedge clock);
      csr_write <= 1;
      csr_index <= CSR_ROWS_A;
      csr_data <= ra;
      @(posedge clock);
      sb.dims[CSR_ROWS_A] = ra;
      csr_index <= CSR_COLS_A;
      csr_data <= ca;
      @(posedge clock);
      sb.dims[CSR_COLS_A] = ca;
      csr_index <= CSR_ROWS_B;
      csr_data <= rb;
      @(posedge clock);
      sb.dims[CSR_ROWS_B] = rb;
      csr_index <= CSR_COLS_B;
      csr_data <= cb;
      @(posedge clock);
      sb.dims[CSR_COLS_B] = cb;
      csr_write <= 0;
   endtask

   // loads for one product plus its start; over adds loads past the needed count
   task run_job(int over);
      int n_a, n_b, la, lb;
      n_a = sb.eff_dim(CSR_ROWS_A) * sb.eff_dim(CSR_COLS_A);
      n_b = sb.eff_dim(CSR_ROWS_B) * sb.eff_dim(CSR_COLS_B);
      la = n_a;
      lb = n_b;
      if (sb.eff_dim(CSR_COLS_A) != sb.eff_dim(CSR_ROWS_B)) begin
         la = $urandom_range(0, 4);
         lb = $urandom_range(0, 4);
      end else if ($urandom % 10 < 2) begin
         la = $urandom_range(0, n_a);
         lb = $urandom_range(0, n_b);
         if (!sb.covered(0, la, n_a)) la = n_a;
         if (!sb.covered(1, lb, n_b)) lb = n_b;
      end else if ($urandom % 10 == 0) begin
         la += $urandom_range(1, 3);
         lb += $urandom_range(1, 3);
      end
      la += over;
      lb += over;
      while (la + lb > 0) begin
         if ($urandom % 12 == 0) begin
            send(FUNC_NONE, $urandom);
         end else if (lb == 0 || (la > 0 && $urandom % 2 == 0)) begin
            send(FUNC_LOAD_A, pick_value());
            la--;
         end else begin
            send(FUNC_LOAD_B, pick_value());
            lb--;
         end
      end
      send(FUNC_START, $urandom);
   endtask

   initial begin
      logic [3:0] ra, ca, rb, cb;
      repeat (8) @(posedge clock);
      reset <= 0;
      @(posedge clock);

      // single elements at the extremes, wrapped product
      send(FUNC_LOAD_A, 32'h8000_0000);
      send(FUNC_LOAD_B, 32'h8000_0000);
      send(FUNC_START, 32'hffff_ffff);
      send(FUNC_NONE, 32'h5a5a_a5a5);
      send(FUNC_LOAD_A, 32'h7fff_ffff);
      send(FUNC_START, 32'h0);
      settle();
      set_dims(4'd2, 4'd3, 4'd3, 4'd2);
      send(FUNC_LOAD_A, 32'h7fff_ffff);
      send(FUNC_LOAD_A, 32'hffff_ffff);
      send(FUNC_LOAD_A, 32'h8000_0000);
      send(FUNC_LOAD_A, 32'h0);
      send(FUNC_LOAD_A, 32'h1);
      send(FUNC_LOAD_A, 32'h7fff_ffff);
      send(FUNC_LOAD_B, 32'h7fff_ffff);
      send(FUNC_LOAD_B, 32'h8000_0000);
      send(FUNC_LOAD_B, 32'hffff_ffff);
      send(FUNC_LOAD_B, 32'h2);
      send(FUNC_LOAD_B, 32'h0);
      send(FUNC_LOAD_B, 32'h7fff_ffff);
      send(FUNC_START, 32'h1234_5678);
      settle();
      set_dims(4'd2, 4'd3, 4'd2, 4'd2);
      send(FUNC_START, 32'h0);

      // full A store with overfill, long receiver hold while a second start queues up
      settle();
      set_dims(4'd15, 4'd8, 4'd8, 4'd1);
      req_calm = 1;
      hold_req = 1;
      run_job(2);
      send(FUNC_LOAD_B, pick_value());
      send(FUNC_LOAD_B, pick_value());
      send(FUNC_START, $urandom);
      req_calm = 0;
      settle();
      set_dims(4'd0, 4'd15, 4'd15, 4'd0);
      run_job(0);

      while (n_items < 160) begin
         settle();
         ra = pick_dim();
         ca = pick_dim();
         rb = ($urandom % 5 == 0) ? pick_dim() : ca;
         cb = pick_dim();
         set_dims(ra, ca, rb, cb);
         req_calm = ($urandom % 4 == 0);
         n_groups++;
         repeat ($urandom_range(1, 3)) run_job(0);
      end

      req_valid <= 0;
      while (sb.product_q.size() != 0) @(posedge clock);
      repeat (200) @(posedge clock);
      if (sb.product_q.size() != 0)
         sb.report($sformatf("%0d results never arrived", sb.product_q.size()));
      $display("covered %0d items over %0d random dimension settings plus directed cases",
               n_items, n_groups);
      $display("checked %0d results, %0d of them dimension errors, %0d mismatches",
               sb.n_checked, sb.n_dim_errors, sb.errors);
      if (sb.errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
